[hw/rtl/polynomial_add_sub_mul_defines.svh]
// Assertion macros shared by the polynomial engine RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef POLYNOMIAL_ADD_SUB_MUL_DEFINES_SVH
`define POLYNOMIAL_ADD_SUB_MUL_DEFINES_SVH

// Plain property checked on every clock edge out of reset.
`define PASM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in the same cycle implies consequent.
`define PASM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PASM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pasm_pkg.sv]
// Shared constants, types and helpers of the polynomial engine.
// No dependencies.
package pasm_pkg;

  localparam int unsigned MaxDegree = 31;
  localparam int unsigned Depth     = MaxDegree + 1;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CountW    = $clog2(Depth + 1);
  localparam int unsigned DegW      = 5;
  localparam int unsigned OpW       = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CoeffW    = 16;
  localparam int unsigned ResW      = 37;
  localparam int unsigned ExpW      = 6;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [OpW-1:0] OpSub    = 2'd1;
  localparam int unsigned    OpMulBit = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFirstDeg  = 2'd0,
    CfgSecondDeg = 2'd1,
    CfgOperation = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              we_first;
    logic              we_second;
    logic [AddrW-1:0]  addr;
    logic [CoeffW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic             mul;
    logic             sub;
    logic [AddrW-1:0] df;
    logic [AddrW-1:0] ds;
  } job_t;

  function automatic logic [AddrW-1:0] eff_deg(logic [DegW-1:0] d);
    if (32'(d) > MaxDegree) begin
      return AddrW'(MaxDegree);
    end
    return AddrW'(d);
  endfunction

endpackage

[hw/rtl/pasm_front.sv]
// Front end: configuration registers, coefficient load counting, job issue.
// Depends on pasm_pkg.
module pasm_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             poly_select_i,
  input  logic signed [pasm_pkg::CoeffW-1:0] coefficient_i,
  input  logic                             cfg_we_i,
  input  logic [pasm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pasm_pkg::DegW-1:0]        cfg_wdata_i,
  input  logic                             done_i,
  output pasm_pkg::mem_wr_t                wr_o,
  output logic                             push_o,
  output pasm_pkg::job_t                   job_o
);

  logic [pasm_pkg::DegW-1:0]   fdeg_q, sdeg_q;
  logic [pasm_pkg::OpW-1:0]    op_q;
  logic [pasm_pkg::CountW-1:0] fcnt_q, fcnt_d, scnt_q, scnt_d;
  logic                        busy_q, busy_d;
  logic [pasm_pkg::AddrW-1:0]  df, ds;
  logic [pasm_pkg::CountW-1:0] df_len, ds_len;
  logic                        accept, f_room, s_room, trigger;

  assign accept = start && !busy_q;
  assign df     = pasm_pkg::eff_deg(fdeg_q);
  assign ds     = pasm_pkg::eff_deg(sdeg_q);
  assign df_len = pasm_pkg::CountW'(df) + pasm_pkg::CountW'(1);
  assign ds_len = pasm_pkg::CountW'(ds) + pasm_pkg::CountW'(1);
  assign f_room = fcnt_q < df_len;
  assign s_room = scnt_q < ds_len;

  always_comb begin
    wr_o.we_first  = accept && !poly_select_i && f_room;
    wr_o.we_second = accept && poly_select_i && s_room;
    wr_o.addr      = poly_select_i ? scnt_q[pasm_pkg::AddrW-1:0]
                                   : fcnt_q[pasm_pkg::AddrW-1:0];
    wr_o.data      = coefficient_i;
    fcnt_d = fcnt_q + pasm_pkg::CountW'(wr_o.we_first);
    scnt_d = scnt_q + pasm_pkg::CountW'(wr_o.we_second);
    trigger = accept && !(fcnt_d < df_len) && !(scnt_d < ds_len);
    busy_d = busy_q;
    if (trigger) begin
      fcnt_d = '0;
      scnt_d = '0;
      busy_d = 1'b1;
    end else if (done_i) begin
      busy_d = 1'b0;
    end
  end

  assign push_o    = trigger;
  assign job_o.mul = op_q[pasm_pkg::OpMulBit];
  assign job_o.sub = (op_q == pasm_pkg::OpSub);
  assign job_o.df  = df;
  assign job_o.ds  = ds;
  assign busy      = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdeg_q <= '0;
      sdeg_q <= '0;
      op_q   <= '0;
      fcnt_q <= '0;
      scnt_q <= '0;
      busy_q <= 1'b0;
    end else begin
      fcnt_q <= fcnt_d;
      scnt_q <= scnt_d;
      busy_q <= busy_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pasm_pkg::CfgFirstDeg:  fdeg_q <= cfg_wdata_i;
          pasm_pkg::CfgSecondDeg: sdeg_q <= cfg_wdata_i;
          pasm_pkg::CfgOperation: op_q   <= cfg_wdata_i[pasm_pkg::OpW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[hw/rtl/pasm_queue.sv]
// Short job queue between front end and compute back end.
// Depends on pasm_pkg and the assertion macro header.
`include "polynomial_add_sub_mul_defines.svh"

module pasm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pasm_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           valid_o,
  output pasm_pkg::job_t job_o
);

  pasm_pkg::job_t               slot_q [pasm_pkg::QDepth];
  logic [pasm_pkg::QPtrW-1:0]   wptr_q, rptr_q;
  logic [pasm_pkg::QCntW-1:0]   cnt_q;
  logic                         full;

  assign valid_o = (cnt_q != '0);
  assign full    = (cnt_q == pasm_pkg::QCntW'(pasm_pkg::QDepth));
  assign job_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (32'(wptr_q) == pasm_pkg::QDepth - 1) ? '0
                                                        : wptr_q + pasm_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (32'(rptr_q) == pasm_pkg::QDepth - 1) ? '0
                                                        : rptr_q + pasm_pkg::QPtrW'(1);
      end
      cnt_q <= cnt_q + pasm_pkg::QCntW'(push_i) - pasm_pkg::QCntW'(pop_i);
    end
  end

  `PASM_ASSERT_IMPL(a_no_overflow, push_i, !full || pop_i, "job queue overflow")
  `PASM_ASSERT_IMPL(a_no_underflow, pop_i, valid_o, "job queue underflow")

endmodule

[hw/rtl/pasm_back.sv]
// Back end: coefficient memories, term sequencer, multiply/add pipeline, output.
// Depends on pasm_pkg and the assertion macro header.
`include "polynomial_add_sub_mul_defines.svh"

module pasm_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pasm_pkg::mem_wr_t                  wr_i,
  input  logic                               job_valid_i,
  input  pasm_pkg::job_t                     job_i,
  output logic                               pop_o,
  output logic                               result_valid_o,
  output logic signed [pasm_pkg::ResW-1:0]   result_coeff_o,
  output logic [pasm_pkg::ExpW-1:0]          exponent_o,
  output logic                               last_o,
  output logic                               done_o
);

  typedef enum logic [1:0] {
    SIdle = 2'b01,
    SRun  = 2'b10
  } state_e;

  typedef struct packed {
    logic                      valid;
    logic                      first;
    logic                      lastk;
    logic                      lastall;
    logic                      mul;
    logic                      sub;
    logic                      za;
    logic                      zb;
    logic [pasm_pkg::ExpW-1:0] k;
  } tag_t;

  logic [pasm_pkg::CoeffW-1:0] mem_a [pasm_pkg::Depth];
  logic [pasm_pkg::CoeffW-1:0] mem_b [pasm_pkg::Depth];

  state_e                     state_q, state_d;
  logic                       mul_q, sub_q, first_q, first_d;
  logic [pasm_pkg::AddrW-1:0] df_q, ds_q, i_q, i_d;
  logic [pasm_pkg::ExpW-1:0]  k_q, k_d, nlast_q, nlast_d, kmin, knext;
  logic [pasm_pkg::ExpW-1:0]  dfx, dsx, jdf, jds;
  logic [pasm_pkg::AddrW-1:0] ia, ib;
  logic                       issue, lastk, lastall;
  tag_t                       t0, s1_q, s2_q;

  logic signed [pasm_pkg::CoeffW-1:0]   rda_q, rdb_q, a_op, b_op;
  logic signed [2*pasm_pkg::CoeffW-1:0] prod;
  logic signed [pasm_pkg::ResW-1:0]     term_q, term_d, acc_q, acc_d;
  logic                                 out_v_q, out_last_q;
  logic signed [pasm_pkg::ResW-1:0]     out_coeff_q;
  logic [pasm_pkg::ExpW-1:0]            out_exp_q;

  // Sequencer
  assign issue = (state_q == SRun);
  assign dfx   = pasm_pkg::ExpW'(df_q);
  assign dsx   = pasm_pkg::ExpW'(ds_q);
  assign jdf   = pasm_pkg::ExpW'(job_i.df);
  assign jds   = pasm_pkg::ExpW'(job_i.ds);
  assign kmin  = (k_q < dfx) ? k_q : dfx;
  assign knext = k_q + pasm_pkg::ExpW'(1);
  assign lastk = !mul_q || (pasm_pkg::ExpW'(i_q) == kmin);
  assign lastall = lastk && (k_q == nlast_q);
  assign ia = mul_q ? i_q : k_q[pasm_pkg::AddrW-1:0];
  assign ib = mul_q ? pasm_pkg::AddrW'(k_q - pasm_pkg::ExpW'(i_q))
                    : k_q[pasm_pkg::AddrW-1:0];

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    i_d     = i_q;
    first_d = first_q;
    nlast_d = nlast_q;
    pop_o   = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          state_d = SRun;
          k_d     = '0;
          i_d     = '0;
          first_d = 1'b1;
          nlast_d = job_i.mul ? jdf + jds : ((jdf > jds) ? jdf : jds);
        end
      end
      SRun: begin
        first_d = lastk;
        if (lastall) begin
          state_d = SIdle;
        end else if (lastk) begin
          k_d = knext;
          i_d = (knext > dsx) ? pasm_pkg::AddrW'(knext - dsx) : '0;
        end else begin
          i_d = i_q + pasm_pkg::AddrW'(1);
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    t0.valid   = issue;
    t0.first   = first_q;
    t0.lastk   = lastk;
    t0.lastall = lastall;
    t0.mul     = mul_q;
    t0.sub     = sub_q;
    t0.za      = !mul_q && (k_q > dfx);
    t0.zb      = !mul_q && (k_q > dsx);
    t0.k       = k_q;
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (wr_i.we_first) begin
      mem_a[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.we_second) begin
      mem_b[wr_i.addr] <= wr_i.data;
    end
    rda_q <= mem_a[ia];
    rdb_q <= mem_b[ib];
  end

  // Term and accumulate
  assign a_op = s1_q.za ? '0 : rda_q;
  assign b_op = s1_q.zb ? '0 : rdb_q;
  assign prod = rda_q * rdb_q;

  always_comb begin
    if (s1_q.mul) begin
      term_d = pasm_pkg::ResW'(prod);
    end else if (s1_q.sub) begin
      term_d = pasm_pkg::ResW'(a_op) - pasm_pkg::ResW'(b_op);
    end else begin
      term_d = pasm_pkg::ResW'(a_op) + pasm_pkg::ResW'(b_op);
    end
    acc_d = (s2_q.first ? '0 : acc_q) + term_q;
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
    if (s2_q.valid && s2_q.lastk) begin
      out_coeff_q <= acc_d;
      out_exp_q   <= s2_q.k;
    end
    if (pop_o) begin
      mul_q <= job_i.mul;
      sub_q <= job_i.sub;
      df_q  <= job_i.df;
      ds_q  <= job_i.ds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      k_q        <= '0;
      i_q        <= '0;
      first_q    <= 1'b0;
      nlast_q    <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      i_q        <= i_d;
      first_q    <= first_d;
      nlast_q    <= nlast_d;
      s1_q       <= t0;
      s2_q       <= s1_q;
      out_v_q    <= s2_q.valid && s2_q.lastk;
      out_last_q <= s2_q.valid && s2_q.lastall;
    end
  end

  assign result_valid_o = out_v_q;
  assign result_coeff_o = out_coeff_q;
  assign exponent_o     = out_exp_q;
  assign last_o         = out_last_q;
  assign done_o         = out_v_q && out_last_q;

  `PASM_ASSERT_IMPL(a_mem_quiet, wr_i.we_first || wr_i.we_second, state_q == SIdle,
                    "coefficient write while a job runs")
  `PASM_ASSERT_NEXT(a_done_idle, done_o, state_q == SIdle && !s1_q.valid,
                    "work left after the final result")

endmodule

[hw/rtl/polynomial_add_sub_mul.sv]
// Top level of the polynomial add / subtract / multiply engine.
// Depends on pasm_pkg, pasm_front, pasm_queue and pasm_back.
//
// Each start transfer loads one coefficient. The transfer that completes both
// operands raises busy, which stays high until the last result strobe; start is
// ignored meanwhile. Results appear on result_valid_o one cycle each and cannot
// be stalled. The first result strobe follows the completing transfer through the
// job queue, the sequencer state, the memory read stage, the term stage and the
// output register. Add and subtract then give one result per cycle, max(first,
// second degree) + 1 results. Multiply runs one multiply-accumulate per cycle
// through the two coefficient memories, one for each pair of coefficients, with
// a result strobe at the end of each exponent's terms. Start may be taken again
// in the cycle after the result flagged last.
module polynomial_add_sub_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               poly_select_i,
  input  logic signed [pasm_pkg::CoeffW-1:0] coefficient_i,
  input  logic                               cfg_we_i,
  input  logic [pasm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pasm_pkg::DegW-1:0]          cfg_wdata_i,
  output logic                               result_valid_o,
  output logic signed [pasm_pkg::ResW-1:0]   result_coeff_o,
  output logic [pasm_pkg::ExpW-1:0]          exponent_o,
  output logic                               last_o
);

  pasm_pkg::mem_wr_t wr;
  pasm_pkg::job_t    push_job, pop_job;
  logic              push, pop, job_valid, done;

  pasm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .poly_select_i (poly_select_i),
    .coefficient_i (coefficient_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_i        (done),
    .wr_o          (wr),
    .push_o        (push),
    .job_o         (push_job)
  );

  pasm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (pop_job)
  );

  pasm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .job_valid_i    (job_valid),
    .job_i          (pop_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_coeff_o (result_coeff_o),
    .exponent_o     (exponent_o),
    .last_o         (last_o),
    .done_o         (done)
  );

endmodule
